### sv/sem_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package sem_pkg;

    // memory size in bytes and the number of byte-lane banks
    localparam int SEM_MEMORY_BYTES = 65536;
    localparam int SEM_LANES        = 8;

    typedef enum logic [0:0] {
        OP_LOAD  = 1'b0,
        OP_STORE = 1'b1
    } op_t;

    // input word
    typedef struct packed {
        op_t         operation;
        logic [1:0]  access_size;
        logic        big_endian;
        logic [31:0] byte_address;
        logic [63:0] store_value;
    } sem_in_t;

    // result word
    typedef struct packed {
        logic [63:0] load_value;
        logic        bounds_fault;
    } sem_out_t;

    // which banks an access touches and the value lane each bank maps to
    typedef struct packed {
        logic [SEM_LANES-1:0]      active;
        logic [SEM_LANES-1:0][2:0] lane;
    } lane_info_t;

endpackage

`default_nettype wire

### sv/sem_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module sem_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8192,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             aclk,
    input  wire logic             en,
    input  wire logic             we,
    input  wire logic [AW-1:0]    addr,
    input  wire logic [WIDTH-1:0] wdata,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // single port, registered read
    always_ff @(posedge aclk) begin
        if (en) begin
            if (we) begin
                mem[addr] <= wdata;
            end
            rdata <= mem[addr];
        end
    end

endmodule

`default_nettype wire

### sv/sem_access_decode.sv
`timescale 1ns / 1ps
`default_nettype none

module sem_access_decode
    import sem_pkg::*;
#(
    parameter int MEMORY_BYTES = SEM_MEMORY_BYTES,
    localparam int ROWS  = (MEMORY_BYTES + SEM_LANES - 1) / SEM_LANES,
    localparam int ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1
) (
    input  wire sem_in_t                        req,
    output logic                                fault,
    output lane_info_t                          info,
    output logic [SEM_LANES-1:0][ROW_W-1:0]     row,
    output logic [SEM_LANES-1:0][7:0]           wdata
);

    logic [32:0]      last_byte;
    logic [2:0]       width_m1;
    logic [2:0]       offset;
    logic [ROW_W-1:0] base_row;

    // bound test on the last byte, no wrap
    always_comb begin
        width_m1  = 3'((4'd1 << req.access_size) - 4'd1);
        last_byte = {1'b0, req.byte_address} + {30'd0, width_m1};
        fault     = (last_byte >= 33'(MEMORY_BYTES));
        offset    = req.byte_address[2:0];
        base_row  = req.byte_address[ROW_W+2:3];
    end

    // per bank: byte index within the access, row, value lane
    always_comb begin
        logic [2:0] idx;
        for (int b = 0; b < SEM_LANES; b++) begin
            idx            = 3'(b) - offset;
            info.active[b] = (idx <= width_m1);
            info.lane[b]   = req.big_endian ? (width_m1 - idx) : idx;
            row[b]         = (3'(b) < offset) ? (base_row + ROW_W'(1)) : base_row;
            wdata[b]       = req.store_value[{info.lane[b], 3'b000} +: 8];
        end
    end

endmodule

`default_nettype wire

### sv/sem_load_assemble.sv
`timescale 1ns / 1ps
`default_nettype none

module sem_load_assemble
    import sem_pkg::*;
(
    input  wire lane_info_t                 info,
    input  wire logic                       load_ok,
    input  wire logic [SEM_LANES-1:0][7:0]  bank_data,
    output logic [63:0]                     load_value
);

    // route each bank byte to its value lane; lanes not touched stay zero
    always_comb begin
        load_value = '0;
        if (load_ok) begin
            for (int b = 0; b < SEM_LANES; b++) begin
                if (info.active[b]) begin
                    load_value[{info.lane[b], 3'b000} +: 8] = bank_data[b];
                end
            end
        end
    end

endmodule

`default_nettype wire

### sv/sized_endian_memory_access_core.sv
`timescale 1ns / 1ps
`default_nettype none

// Byte-addressed load/store unit over eight byte-lane RAM banks of
// ceil(MEMORY_BYTES/8) rows each. Any 1, 2, 4 or 8 byte access, aligned or
// not, touches each bank at most once, so one word is accepted per cycle
// while s_ready is high. The bank read is registered at the accepting edge
// and the result word is registered when the bank stage advances, which
// raises m_valid; stores and faulting accesses go through the same two
// stages. Once the sweep is done, s_ready drops only while both stages hold
// words and m_ready is low. After reset the banks are swept to zero one row
// per cycle, all ceil(MEMORY_BYTES/8) rows (8192 at the default size), while
// s_ready stays low. Accesses whose last byte lies at or beyond MEMORY_BYTES
// return bounds_fault and write nothing.
module sized_endian_memory_access_core
    import sem_pkg::*;
#(
    parameter int MEMORY_BYTES = SEM_MEMORY_BYTES
) (
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     s_valid,
    output logic          s_ready,
    input  wire sem_in_t  s_data,
    output logic          m_valid,
    input  wire logic     m_ready,
    output sem_out_t      m_data
);

    localparam int ROWS  = (MEMORY_BYTES + SEM_LANES - 1) / SEM_LANES;
    localparam int ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;

    logic [ROW_W:0] clear_cnt_reg, clear_cnt_next;
    logic           clear_done;

    logic                            dec_fault;
    lane_info_t                      dec_info;
    logic [SEM_LANES-1:0][ROW_W-1:0] dec_row;
    logic [SEM_LANES-1:0][7:0]       dec_wdata;

    logic                      p1_valid_reg, p1_valid_next;
    logic                      p1_fault_reg, p1_fault_next;
    logic                      p1_load_ok_reg, p1_load_ok_next;
    lane_info_t                p1_info_reg, p1_info_next;
    logic [SEM_LANES-1:0][7:0] bank_rdata;
    logic [63:0]               asm_value;

    logic     m_valid_reg, m_valid_next;
    sem_out_t m_data_reg, m_data_next;

    logic accept;
    logic p1_adv;

    // handshake
    assign clear_done = (clear_cnt_reg == (ROW_W+1)'(ROWS));
    assign p1_adv     = p1_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready    = clear_done && (!p1_valid_reg || !m_valid_reg || m_ready);
    assign accept     = s_valid && s_ready;
    assign m_valid    = m_valid_reg;
    assign m_data     = m_data_reg;

    sem_access_decode #(
        .MEMORY_BYTES (MEMORY_BYTES)
    ) u_decode (
        .req   (s_data),
        .fault (dec_fault),
        .info  (dec_info),
        .row   (dec_row),
        .wdata (dec_wdata)
    );

    // byte-lane banks; clearing sweep shares the port
    for (genvar b = 0; b < SEM_LANES; b++) begin : g_bank
        logic             bank_en;
        logic             bank_we;
        logic [ROW_W-1:0] bank_addr;
        logic [7:0]       bank_wd;

        always_comb begin
            if (!clear_done) begin
                bank_en   = 1'b1;
                bank_we   = 1'b1;
                bank_addr = clear_cnt_reg[ROW_W-1:0];
                bank_wd   = '0;
            end else begin
                bank_en   = accept && !dec_fault && dec_info.active[b];
                bank_we   = (s_data.operation == OP_STORE);
                bank_addr = dec_row[b];
                bank_wd   = dec_wdata[b];
            end
        end

        sem_ram #(
            .WIDTH (8),
            .DEPTH (ROWS)
        ) u_ram (
            .aclk  (aclk),
            .en    (bank_en),
            .we    (bank_we),
            .addr  (bank_addr),
            .wdata (bank_wd),
            .rdata (bank_rdata[b])
        );
    end

    sem_load_assemble u_assemble (
        .info       (p1_info_reg),
        .load_ok    (p1_load_ok_reg),
        .bank_data  (bank_rdata),
        .load_value (asm_value)
    );

    // next-state logic for the sweep, the bank stage and the output register
    always_comb begin
        clear_cnt_next  = clear_cnt_reg;
        p1_valid_next   = p1_valid_reg;
        p1_fault_next   = p1_fault_reg;
        p1_load_ok_next = p1_load_ok_reg;
        p1_info_next    = p1_info_reg;
        m_valid_next    = m_valid_reg;
        m_data_next     = m_data_reg;

        if (!clear_done) begin
            clear_cnt_next = clear_cnt_reg + (ROW_W+1)'(1);
        end

        if (m_ready) begin
            m_valid_next = 1'b0;
        end
        if (p1_adv) begin
            m_valid_next             = 1'b1;
            m_data_next.load_value   = asm_value;
            m_data_next.bounds_fault = p1_fault_reg;
            p1_valid_next            = 1'b0;
        end

        if (accept) begin
            p1_valid_next   = 1'b1;
            p1_fault_next   = dec_fault;
            p1_load_ok_next = !dec_fault && (s_data.operation == OP_LOAD);
            p1_info_next    = dec_info;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clear_cnt_reg <= '0;
            p1_valid_reg  <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            clear_cnt_reg <= clear_cnt_next;
            p1_valid_reg  <= p1_valid_next;
            m_valid_reg   <= m_valid_next;
        end
        p1_fault_reg   <= p1_fault_next;
        p1_load_ok_reg <= p1_load_ok_next;
        p1_info_reg    <= p1_info_next;
        m_data_reg     <= m_data_next;
    end

`ifndef NO_ASSERTIONS
    // no word enters while the banks are being cleared
    a_no_accept_in_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |-> clear_done)
        else $error("word accepted during clearing sweep");

    // an accepted word always occupies the bank stage next cycle
    a_accept_fills_stage: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> p1_valid_reg)
        else $error("accepted word lost before bank stage");

    // a faulting access never reports data
    a_fault_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.bounds_fault) |-> (m_data.load_value == 64'd0))
        else $error("faulting access returned data");

    // a store or faulting access in the bank stage assembles zero
    a_nonload_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (p1_valid_reg && !p1_load_ok_reg) |-> (asm_value == 64'd0))
        else $error("non-load produced load data");
`endif

endmodule

`default_nettype wire
